// ----- design/assert_macros.svh -----
// Assertion macros shared by the frame receiver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define FRM_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/frm_pkg.sv -----
// Package for the frame receiver: constants, codes, types and helpers.
package frm_pkg;

  localparam int BUFFER_DEPTH   = 64;
  localparam int ADDR_W         = $clog2(BUFFER_DEPTH);
  localparam int CNT_W          = ($clog2(BUFFER_DEPTH + 2) > 6) ?
                                  $clog2(BUFFER_DEPTH + 2) : 6;
  localparam int FRAME_OVERHEAD = 3 + 1 + 1;  // header, two length bytes, two trailer bytes
  localparam logic [15:0] LEN_LIMIT = 16'(BUFFER_DEPTH - FRAME_OVERHEAD);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 1'd1;
  localparam logic [7:0] HEADER_RESET      = 8'h59;
  localparam logic [5:0] MAX_PAYLOAD_RESET = 6'd50;

  // word actions
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_REARM = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // phase codes as seen on the result channel
  localparam logic [2:0] PHASE_CODE_STOP   = 3'd0;
  localparam logic [2:0] PHASE_CODE_HUNT   = 3'd1;
  localparam logic [2:0] PHASE_CODE_LEN_LO = 3'd2;
  localparam logic [2:0] PHASE_CODE_LEN_HI = 3'd3;
  localparam logic [2:0] PHASE_CODE_BODY   = 3'd4;

  typedef enum logic [4:0] {
    PH_STOP   = 5'b00001,
    PH_HUNT   = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_LEN_HI = 5'b01000,
    PH_BODY   = 5'b10000
  } frm_phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [5:0] read_index;
  } frm_in_t;

  typedef struct packed {
    logic        frame_done;
    logic        busy_res;
    logic [2:0]  phase;
    logic [5:0]  byte_count;
    logic [15:0] frame_length;
    logic [7:0]  read_data;
  } frm_out_t;

  // handshake between the input register and the core
  typedef struct packed {
    logic    valid;
    frm_in_t item;
  } frm_stage_t;

  function automatic logic [2:0] phase_code(frm_phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_STOP:   code = PHASE_CODE_STOP;
      PH_HUNT:   code = PHASE_CODE_HUNT;
      PH_LEN_LO: code = PHASE_CODE_LEN_LO;
      PH_LEN_HI: code = PHASE_CODE_LEN_HI;
      PH_BODY:   code = PHASE_CODE_BODY;
      default:   code = PHASE_CODE_STOP;
    endcase
    return code;
  endfunction

endpackage

// ----- design/frm_chan_if.sv -----
// Valid/ready channel interfaces for the receiver's words and results.
interface frm_in_if;
  import frm_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic [5:0] read_index;

  modport source (output valid, output action, output data_byte, output read_index,
                  input ready);
  modport sink   (input valid, input action, input data_byte, input read_index,
                  output ready);
endinterface

interface frm_out_if;
  import frm_pkg::*;

  logic        valid;
  logic        ready;
  logic        frame_done;
  logic        busy_res;
  logic [2:0]  phase;
  logic [5:0]  byte_count;
  logic [15:0] frame_length;
  logic [7:0]  read_data;

  modport source (output valid, output frame_done, output busy_res, output phase,
                  output byte_count, output frame_length, output read_data,
                  input ready);
  modport sink   (input valid, input frame_done, input busy_res, input phase,
                  input byte_count, input frame_length, input read_data,
                  output ready);
endinterface

// ----- design/frm_in_stage.sv -----
// Input register: holds one accepted word until the core takes it.
`include "assert_macros.svh"

module frm_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  frm_pkg::frm_in_t   in_item,
  output frm_pkg::frm_stage_t stage,
  input  logic               take
);
  import frm_pkg::*;

  logic    valid_r;
  frm_in_t item_r;

  // a word may enter while the held one leaves in the same cycle
  assign in_ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

  `FRM_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_valid && in_ready, valid_r,
                   "accepted word not held in input register")
  `FRM_ASSERT_NEXT(a_held_word_kept, clk, rst_n, valid_r && !take,
                   valid_r && $stable(item_r), "held word lost or changed")
  `FRM_ASSERT_ALWAYS(a_take_needs_word, clk, rst_n, !take || valid_r,
                     "core took a word from an empty input register")

endmodule

// ----- design/frm_core.sv -----
// Receiver core: frame state update, frame buffer and result register.
`include "assert_macros.svh"

module frm_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  frm_pkg::frm_stage_t             stage,
  output logic                            take,
  output logic                            out_valid,
  input  logic                            out_ready,
  output frm_pkg::frm_out_t               out_item,
  input  logic                            cfg_we,
  input  logic [frm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import frm_pkg::*;

  // configuration
  logic [7:0] header_r;
  logic [5:0] max_payload_r;

  // frame state
  frm_phase_t       phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      length_r, length_nxt;
  logic             done_r, done_nxt;
  logic             busy_r, busy_nxt;

  // buffer
  logic [7:0]        frame_mem [BUFFER_DEPTH];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_hit;
  logic [7:0]        rd_data_r;

  // result register
  logic       out_valid_r;
  logic       done_out_r;
  logic       busy_out_r;
  logic [2:0] phase_out_r;
  logic [5:0] count_out_r;
  logic [15:0] length_out_r;

  logic             advance;
  logic [15:0]      len_cat;
  logic             oversize;
  logic [CNT_W-1:0] count_inc;
  logic [16:0]      frame_total;
  logic [16:0]      count_ext;

  assign advance = stage.valid && (!out_valid_r || out_ready);
  assign take    = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r      <= HEADER_RESET;
      max_payload_r <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER:      header_r      <= cfg_wdata;
        REG_MAX_PAYLOAD: max_payload_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  assign len_cat     = {stage.item.data_byte, length_r[7:0]};
  assign oversize    = (len_cat > {10'd0, max_payload_r}) || (len_cat > LEN_LIMIT);
  assign count_inc   = count_r + CNT_W'(1);
  assign frame_total = {1'b0, length_r} + 17'(FRAME_OVERHEAD);
  assign count_ext   = 17'(count_inc);

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    length_nxt = length_r;
    done_nxt   = done_r;
    busy_nxt   = busy_r;
    wr_en      = 1'b0;
    wr_addr    = count_r[ADDR_W-1:0];
    rd_hit     = 1'b0;
    case (stage.item.action)
      ACT_BYTE: begin
        if (phase_r != PH_STOP && phase_r != PH_HUNT) begin
          busy_nxt = 1'b1;
        end
        unique case (phase_r)
          PH_HUNT: begin
            if (stage.item.data_byte == header_r) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              count_nxt = CNT_W'(1);
              phase_nxt = PH_LEN_LO;
              done_nxt  = 1'b0;
            end
          end
          PH_LEN_LO: begin
            wr_en      = count_r < CNT_W'(BUFFER_DEPTH);
            count_nxt  = count_inc;
            length_nxt = {8'd0, stage.item.data_byte};
            phase_nxt  = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            wr_en      = count_r < CNT_W'(BUFFER_DEPTH);
            count_nxt  = count_inc;
            length_nxt = len_cat;
            phase_nxt  = oversize ? PH_HUNT : PH_BODY;
          end
          PH_BODY: begin
            wr_en     = count_r < CNT_W'(BUFFER_DEPTH);
            count_nxt = count_inc;
            if (count_ext == frame_total) begin
              done_nxt  = 1'b1;
              busy_nxt  = 1'b0;
              phase_nxt = PH_STOP;
            end else if (count_ext > frame_total) begin
              phase_nxt = PH_HUNT;
            end
          end
          PH_STOP: ;
          default: ;
        endcase
      end
      ACT_REARM: begin
        phase_nxt = PH_HUNT;
        count_nxt = '0;
        busy_nxt  = 1'b0;
      end
      ACT_READ: begin
        rd_hit = CNT_W'(stage.item.read_index) < CNT_W'(BUFFER_DEPTH);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      count_r  <= '0;
      length_r <= '0;
      done_r   <= 1'b0;
      busy_r   <= 1'b0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      length_r <= length_nxt;
      done_r   <= done_nxt;
      busy_r   <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      frame_mem[wr_addr] <= stage.item.data_byte;
    end
  end

  // read sees every write of earlier words; a read word never writes
  always_ff @(posedge clk) begin
    if (advance) begin
      rd_data_r <= rd_hit ? frame_mem[ADDR_W'(stage.item.read_index)] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      done_out_r   <= done_nxt;
      busy_out_r   <= busy_nxt;
      phase_out_r  <= phase_code(phase_nxt);
      count_out_r  <= count_nxt[5:0];
      length_out_r <= length_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_item.frame_done   = done_out_r;
  assign out_item.busy_res     = busy_out_r;
  assign out_item.phase        = phase_out_r;
  assign out_item.byte_count   = count_out_r;
  assign out_item.frame_length = length_out_r;
  assign out_item.read_data    = rd_data_r;

  `FRM_ASSERT_ALWAYS(a_phase_onehot, clk, rst_n, $onehot(phase_r),
                     "phase register not one-hot")
  `FRM_ASSERT_ALWAYS(a_done_not_busy, clk, rst_n, !(done_r && busy_r),
                     "done and busy set together")
  `FRM_ASSERT_ALWAYS(a_count_in_buffer, clk, rst_n, count_r <= CNT_W'(BUFFER_DEPTH),
                     "byte count beyond buffer")
  `FRM_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_r,
                   "processed word produced no result")

endmodule

// ----- design/length_prefixed_frame_receiver.sv -----
// Length-prefixed frame receiver: top level joining input register and core.
//
// Usage: words arrive on in_ch (valid/ready). action 0 feeds one received
// serial byte, 1 rearms the receiver, 2 reads one byte of the frame buffer.
// Every accepted word gives exactly one result word on out_ch (valid/ready)
// carrying done, busy, phase, byte count, frame length and read data, all
// taken after the word has been applied.
// An accepted word is held in the input register, then processed into the
// result register, from which its result can be taken. Throughput is one
// word per cycle while out_ch takes results; the single-pass state update
// and the one-write/one-read buffer memory set that figure.
// Configuration (header byte, max payload) is written through cfg_we,
// cfg_index and cfg_wdata while no word is in flight.
// Reset (rst_n low, synchronous) puts the receiver into header hunt with
// count, length, done and busy cleared; buffer contents are undefined until
// a frame writes them. When out_ch stalls, the result is held, one more word
// waits in the input register, and in_ch.ready then drops.
module length_prefixed_frame_receiver (
  input  logic                            clk,
  input  logic                            rst_n,
  frm_in_if.sink                          in_ch,
  frm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [frm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import frm_pkg::*;

  frm_in_t    in_item;
  frm_stage_t stage;
  frm_out_t   out_item;
  logic       take;
  logic       in_ready;
  logic       out_valid;

  assign in_item.action     = in_ch.action;
  assign in_item.data_byte  = in_ch.data_byte;
  assign in_item.read_index = in_ch.read_index;
  assign in_ch.ready        = in_ready;

  frm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .stage    (stage),
    .take     (take)
  );

  frm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.frame_done   = out_item.frame_done;
  assign out_ch.busy_res     = out_item.busy_res;
  assign out_ch.phase        = out_item.phase;
  assign out_ch.byte_count   = out_item.byte_count;
  assign out_ch.frame_length = out_item.frame_length;
  assign out_ch.read_data    = out_item.read_data;

endmodule

// ----- tb/length_prefixed_frame_receiver_tb.sv -----
// Testbench for the length-prefixed frame receiver: scoreboard class, stimulus and checks.
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_tb;
  import frm_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Mirrors the receiver state word by word and holds the results still owed.
  class frame_capture_scoreboard;
    logic [7:0]  header;
    logic [5:0]  max_len;
    logic [2:0]  rx_phase;
    int          count;
    logic [15:0] length;
    logic        done;
    logic        busy;
    logic [7:0]  store [BUFFER_DEPTH];
    bit [BUFFER_DEPTH-1:0] written;
    frm_out_t    expected_q[$];
    int          errors;
    int          shown;
    int          words;
    int          results;
    int          frames;
    int          drops;

    function new();
      header   = HEADER_RESET;
      max_len  = MAX_PAYLOAD_RESET;
      rx_phase = PHASE_CODE_HUNT;
      count    = 0;
      length   = '0;
      done     = 1'b0;
      busy     = 1'b0;
      written  = '0;
      errors   = 0;
      shown    = 0;
      words    = 0;
      results  = 0;
      frames   = 0;
      drops    = 0;
    endfunction

    function void store_byte(logic [7:0] b);
      if (count < BUFFER_DEPTH) begin
        store[count]   = b;
        written[count] = 1'b1;
      end
      count++;
    endfunction

    function void take_byte(logic [7:0] b);
      int total;
      if (rx_phase > PHASE_CODE_HUNT) busy = 1'b1;
      case (rx_phase)
        PHASE_CODE_HUNT: begin
          if (b == header) begin
            count = 0;
            store_byte(b);
            rx_phase = PHASE_CODE_LEN_LO;
            done = 1'b0;
          end
        end
        PHASE_CODE_LEN_LO: begin
          store_byte(b);
          length = {8'h00, b};
          rx_phase = PHASE_CODE_LEN_HI;
        end
        PHASE_CODE_LEN_HI: begin
          store_byte(b);
          length[15:8] = b;
          rx_phase = PHASE_CODE_BODY;
          // oversize frame: back to hunting, busy stays set
          if (int'(length) > int'(max_len) ||
              int'(length) + FRAME_OVERHEAD > BUFFER_DEPTH) begin
            rx_phase = PHASE_CODE_HUNT;
            drops++;
          end
        end
        PHASE_CODE_BODY: begin
          store_byte(b);
          total = int'(length) + FRAME_OVERHEAD;
          if (count == total) begin
            done = 1'b1;
            busy = 1'b0;
            rx_phase = PHASE_CODE_STOP;
            frames++;
          end else if (count > total) begin
            rx_phase = PHASE_CODE_HUNT;
          end
        end
        default: ;
      endcase
    endfunction

    function void note_word(frm_in_t w);
      frm_out_t r;
      r = '0;
      words++;
      case (w.action)
        ACT_BYTE:  take_byte(w.data_byte);
        ACT_REARM: begin
          rx_phase = PHASE_CODE_HUNT;
          count = 0;
          busy = 1'b0;
        end
        ACT_READ:  r.read_data = store[w.read_index];
        default: ;
      endcase
      r.frame_done   = done;
      r.busy_res     = busy;
      r.phase        = rx_phase;
      r.byte_count   = count[5:0];
      r.frame_length = length;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        if (shown < 60) begin
          $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, got_v);
          shown++;
        end
      end
    endfunction

    function void check_result(frm_out_t got);
      frm_out_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expected none, actual %h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      results++;
      compare_field("frame_done", 16'(exp_r.frame_done), 16'(got.frame_done));
      compare_field("busy_res", 16'(exp_r.busy_res), 16'(got.busy_res));
      compare_field("phase", 16'(exp_r.phase), 16'(got.phase));
      compare_field("byte_count", 16'(exp_r.byte_count), 16'(got.byte_count));
      compare_field("frame_length", exp_r.frame_length, got.frame_length);
      compare_field("read_data", 16'(exp_r.read_data), 16'(got.read_data));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  frm_in_if  in_ch ();
  frm_out_if out_ch ();

  length_prefixed_frame_receiver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  frame_capture_scoreboard sb;
  int burst_left = 0;
  int n_settings = 0;
  logic [7:0] stall_pattern = 8'hFF;
  int pattern_left = 0;

  always #10 clk = ~clk;

  // receiver: rotate a stall pattern, pick a fresh one every so often
  always @(posedge clk) begin
    if (pattern_left == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = 8'hFF;
        1:       stall_pattern = 8'($urandom_range(1, 255));
        2:       stall_pattern = 8'b0110_1001;
        default: stall_pattern = 8'b1000_0001;
      endcase
      pattern_left = $urandom_range(16, 96);
    end
    pattern_left--;
    out_ch.ready <= stall_pattern[0];
    stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(frm_out_t'{frame_done: out_ch.frame_done, busy_res: out_ch.busy_res,
                                 phase: out_ch.phase, byte_count: out_ch.byte_count,
                                 frame_length: out_ch.frame_length,
                                 read_data: out_ch.read_data});
  end

  task automatic send_word(logic [1:0] act, logic [7:0] data, logic [5:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.data_byte  <= data;
    in_ch.read_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(frm_in_t'{action: act, data_byte: data, read_index: idx});
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // only called with nothing in flight
  task automatic write_frame_regs(logic [7:0] hdr, logic [5:0] mx);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HEADER;
    cfg_wdata <= hdr;
    @(posedge clk);
    sb.header = hdr;
    cfg_index <= REG_MAX_PAYLOAD;
    cfg_wdata <= {2'b00, mx};
    @(posedge clk);
    sb.max_len = mx;
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic send_frame(int len, logic [7:0] hi, bit cut);
    int body;
    int stop_at;
    if (sb.rx_phase != PHASE_CODE_HUNT)
      send_word(ACT_REARM, 8'($urandom), 6'($urandom));
    send_word(ACT_BYTE, sb.header, 6'($urandom));
    send_word(ACT_BYTE, 8'(len), 6'($urandom));
    send_word(ACT_BYTE, hi, 6'($urandom));
    // an oversize frame gets a few stray bytes after it instead of a body
    body = (int'({hi, 8'(len)}) > int'(sb.max_len)) ? $urandom_range(0, 2) : len + 2;
    stop_at = cut ? $urandom_range(0, body) : body;
    for (int i = 0; i < body; i++) begin
      if (i == stop_at) begin
        send_word(ACT_REARM, 8'($urandom), 6'($urandom));
        break;
      end
      send_word(ACT_BYTE, 8'($urandom), 6'($urandom));
    end
  endtask

  task automatic read_some();
    int n;
    int idx;
    n = $urandom_range(1, 4);
    if (sb.written == '0) return;
    for (int i = 0; i < n; i++) begin
      do idx = $urandom_range(0, BUFFER_DEPTH - 1); while (!sb.written[idx]);
      send_word(ACT_READ, 8'($urandom), 6'(idx));
    end
  endtask

  task automatic run_traffic(int n);
    int stop_words;
    int pick;
    int sel;
    int len;
    int short_cap;
    logic [7:0] hi;
    stop_words = sb.words + n;
    while (sb.words < stop_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        sel = $urandom_range(0, 19);
        hi = 8'h00;
        short_cap = (sb.max_len < 6) ? int'(sb.max_len) : 6;
        if (sel < 17) len = $urandom_range(0, short_cap);
        else if (sel == 17) len = sb.max_len;
        else if (sel == 18) len = int'(sb.max_len) + $urandom_range(1, 20);
        else begin
          len = $urandom_range(0, 255);
          hi = 8'($urandom_range(1, 255));
        end
        send_frame(len, hi, $urandom_range(0, 19) == 0);
      end else if (pick < 75) begin
        read_some();
      end else if (pick < 88) begin
        send_word(ACT_BYTE, 8'($urandom), 6'($urandom));
      end else if (pick < 94) begin
        send_word(ACT_REARM, 8'($urandom), 6'($urandom));
      end else if (pick < 97) begin
        send_word(ACT_UNUSED, 8'($urandom), 6'($urandom));
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_BYTE;
    in_ch.data_byte  <= 8'h00;
    in_ch.read_index <= 6'd0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_HEADER;
    cfg_wdata        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_frame_regs(HEADER_RESET, MAX_PAYLOAD_RESET);

    // directed: stray byte in hunt, unused action, shortest frame
    send_word(ACT_BYTE, 8'h00, 6'h3F);
    send_word(ACT_UNUSED, 8'hFF, 6'h00);
    send_word(ACT_BYTE, HEADER_RESET, 6'h00);
    send_word(ACT_BYTE, 8'h00, 6'h15);
    send_word(ACT_BYTE, 8'h00, 6'h2A);
    send_word(ACT_BYTE, 8'hFF, 6'h3F);
    send_word(ACT_BYTE, 8'h00, 6'h00);
    // header while stopped is ignored
    send_word(ACT_BYTE, HEADER_RESET, 6'h3F);
    send_word(ACT_READ, 8'hFF, 6'd0);
    send_word(ACT_READ, 8'h00, 6'd3);
    send_word(ACT_READ, 8'hAA, 6'd4);
    send_word(ACT_REARM, 8'h55, 6'h3F);
    // oversize by one, then the largest length word
    send_word(ACT_BYTE, HEADER_RESET, 6'h00);
    send_word(ACT_BYTE, 8'(MAX_PAYLOAD_RESET + 1), 6'h00);
    send_word(ACT_BYTE, 8'h00, 6'h00);
    send_word(ACT_BYTE, HEADER_RESET, 6'h00);
    send_word(ACT_BYTE, 8'hFF, 6'h00);
    send_word(ACT_BYTE, 8'hFF, 6'h00);
    send_word(ACT_REARM, 8'h00, 6'h00);
    // rearm in the middle of a frame
    send_word(ACT_BYTE, HEADER_RESET, 6'h00);
    send_word(ACT_BYTE, 8'h02, 6'h00);
    send_word(ACT_REARM, 8'hFF, 6'h3F);
    drain_results();

    for (int s = 0; s < 5; s++) begin
      case (s)
        0:       write_frame_regs(8'h00, 6'd0);
        1:       write_frame_regs(8'hFF, 6'd59);
        2:       write_frame_regs(8'($urandom), 6'($urandom_range(0, 59)));
        3:       write_frame_regs(HEADER_RESET, 6'($urandom_range(1, 58)));
        default: write_frame_regs(8'($urandom), 6'd59);
      endcase
      run_traffic(126);
      drain_results();
    end
    repeat (4) @(posedge clk);

    if (sb.expected_q.size() != 0) begin
      sb.errors += sb.expected_q.size();
      $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
    end
    $display("Sent %0d words over %0d register settings; checked %0d results.",
             sb.words, n_settings, sb.results);
    $display("Frames captured: %0d, oversize frames dropped: %0d, errors: %0d.",
             sb.frames, sb.drops, sb.errors);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
